FILE: rtl/tbc_pkg.sv
package tbc_pkg;

  // Tempo parameters.
  localparam int TICKS_PER_BAR = 960;
  localparam int BPM_MIN       = 1;
  localparam int BPM_MAX       = 300;
  localparam int US_PER_MIN    = 60000000;
  localparam int QUARTER_TICKS = TICKS_PER_BAR / 4;

  // Field and state widths.
  localparam int MODE_W    = 2;
  localparam int ELAPSED_W = 16;
  localparam int BPM_W     = 10;
  localparam int BPB_W     = 5;
  localparam int IDX_W     = 13;
  localparam int ACC_W     = 32;
  localparam int SUM_W     = ACC_W + 1;

  // Divider widths, derived from the tempo parameters.
  localparam int US_W   = $clog2(US_PER_MIN + 1);
  localparam int DIVR_W = $clog2(BPM_MAX * QUARTER_TICKS + 1);
  localparam int DUR_W  = $clog2(US_PER_MIN / (BPM_MIN * QUARTER_TICKS) + 1);
  localparam int DVS_W  = (DUR_W > DIVR_W) ? DUR_W : DIVR_W;
  localparam int DVD_W  = SUM_W;
  localparam int ITER_W = $clog2(DVD_W + 1);
  localparam int CNT_W  = $clog2(TICKS_PER_BAR);
  localparam int TPB_W  = $clog2(TICKS_PER_BAR + 1);

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = ((ELAPSED_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = IDX_W + 3;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [MODE_W-1:0] MODE_ADVANCE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_START   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_STOP    = MODE_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BEATS_PER_BAR = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_DUR,
    OP_REM,
    OP_SPC,
    OP_BEAT
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUR,
    ST_CHK,
    ST_REM,
    ST_SPC,
    ST_BEAT,
    ST_DONE
  } tbc_state_e;

  typedef struct packed {
    logic    cap;
    logic    start;
    div_op_e start_op;
    logic    chk;
    logic    take;
    div_op_e take_op;
    logic    commit;
  } tbc_cmd_t;

  typedef struct packed {
    logic go_adv;
    logic div_busy;
    logic sum_ge;
    logic cnt_neg;
    logic out_free;
  } tbc_sts_t;

endpackage

FILE: rtl/tempo_tick_beat_clock.sv
// Tempo clock that turns start, stop and time advance requests into ticks at
// 960 per bar; one tick lasts floor(60000000 / (bpm * 240)) microseconds with
// the tempo clamped to 1..300 bpm, and every request yields exactly one result
// word. Requests are handled one at a time. Start, stop and ignored requests
// use no division; an advance without a tick works out only the tick
// duration, and one that fires a tick also the carried remainder, the beat
// spacing and, but for the first tick after a start, the beat test. All are
// done by a single serial restoring divider, one quotient bit per cycle. The
// result sits in an output register, so the next request is taken while the
// previous result waits.
module tempo_tick_beat_clock (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // elapsed_us [15:0]
  input  logic [tbc_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // mode [1:0]
  input  logic [tbc_pkg::MODE_W-1:0]       s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // tick [0], beat [1], tick_index [14:2], running [15]
  output logic [tbc_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  tbc_pkg::tbc_cmd_t cmd;
  tbc_pkg::tbc_sts_t sts;

  tbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

FILE: rtl/tbc_div.sv
module tbc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tbc_pkg::DVD_W-1:0]   dividend_i,
  input  logic [tbc_pkg::DVS_W-1:0]   divisor_i,
  input  logic [tbc_pkg::ITER_W-1:0]  iters_i,
  output logic                        busy_o,
  output logic [tbc_pkg::DVD_W-1:0]   quot_o,
  output logic [tbc_pkg::DVS_W-1:0]   rem_o
);

  logic [tbc_pkg::ITER_W-1:0] cnt_q, cnt_d;
  logic [tbc_pkg::DVD_W-1:0]  dvd_q, dvd_d;
  logic [tbc_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [tbc_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [tbc_pkg::DVS_W:0]    shifted;
  logic [tbc_pkg::DVS_W+1:0]  diff;

  // One restoring step per cycle. The dividend arrives left aligned, so after
  // the given number of steps the whole shift register holds the quotient.
  always_comb begin
    shifted = {rem_q, dvd_q[tbc_pkg::DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    if (start_i) begin
      cnt_d = iters_i;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - tbc_pkg::ITER_W'(1);
      if (!diff[tbc_pkg::DVS_W+1]) begin
        rem_d = diff[tbc_pkg::DVS_W-1:0];
        dvd_d = {dvd_q[tbc_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[tbc_pkg::DVS_W-1:0];
        dvd_d = {dvd_q[tbc_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("divider restarted while busy");

endmodule

FILE: rtl/tbc_dp.sv
module tbc_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tbc_pkg::tbc_cmd_t                cmd_i,
  output tbc_pkg::tbc_sts_t                sts_o,
  input  logic [tbc_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  input  logic [tbc_pkg::MODE_W-1:0]       s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [tbc_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam logic [tbc_pkg::DVD_W-1:0] DUR_DVD =
    tbc_pkg::DVD_W'(tbc_pkg::US_PER_MIN) << (tbc_pkg::DVD_W - tbc_pkg::US_W);
  localparam logic [tbc_pkg::DVD_W-1:0] SPC_DVD =
    tbc_pkg::DVD_W'(tbc_pkg::TICKS_PER_BAR) << (tbc_pkg::DVD_W - tbc_pkg::TPB_W);

  logic [tbc_pkg::BPM_W-1:0]      bpm_q, bpm_d;
  logic [tbc_pkg::BPB_W-1:0]      bpb_q, bpb_d;
  logic                           playing_q, playing_d;
  logic [tbc_pkg::DUR_W-1:0]      carry_q, carry_d;
  logic [tbc_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic [tbc_pkg::IDX_W-1:0]      count_q, count_d;
  logic [tbc_pkg::MODE_W-1:0]     mode_q, mode_d;
  logic [tbc_pkg::ELAPSED_W-1:0]  elapsed_q, elapsed_d;
  logic [tbc_pkg::DUR_W-1:0]      dur_q, dur_d;
  logic [tbc_pkg::DUR_W-1:0]      carry_n_q, carry_n_d;
  logic                           fire_q, fire_d;
  logic                           beat_q, beat_d;
  logic                           m_valid_q, m_valid_d;
  logic [tbc_pkg::OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic [tbc_pkg::BPM_W-1:0]      bpm_c;
  logic [tbc_pkg::DIVR_W-1:0]     divr;
  logic [tbc_pkg::DVS_W-1:0]      bpb_c;
  logic [tbc_pkg::SUM_W-1:0]      sum;
  logic [tbc_pkg::ACC_W-1:0]      acc_base;
  logic [tbc_pkg::SUM_W-1:0]      acc_sum;
  logic [tbc_pkg::IDX_W-1:0]      count_inc;
  logic [tbc_pkg::TPB_W-1:0]      spc_val;
  logic                           out_free;

  logic                           div_start;
  logic [tbc_pkg::DVD_W-1:0]      div_dvd;
  logic [tbc_pkg::DVS_W-1:0]      div_dvs;
  logic [tbc_pkg::ITER_W-1:0]     div_iters;
  logic                           div_busy;
  logic [tbc_pkg::DVD_W-1:0]      div_quot;
  logic [tbc_pkg::DVS_W-1:0]      div_rem;

  tbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (bpm_q < tbc_pkg::BPM_W'(tbc_pkg::BPM_MIN)) begin
      bpm_c = tbc_pkg::BPM_W'(tbc_pkg::BPM_MIN);
    end else if (bpm_q >= tbc_pkg::BPM_W'(tbc_pkg::BPM_MAX)) begin
      bpm_c = tbc_pkg::BPM_W'(tbc_pkg::BPM_MAX);
    end else begin
      bpm_c = bpm_q;
    end
    divr = tbc_pkg::DIVR_W'(bpm_c * tbc_pkg::QUARTER_TICKS);
    if (divr == '0) begin
      divr = tbc_pkg::DIVR_W'(1);
    end
    bpb_c = (bpb_q == '0) ? tbc_pkg::DVS_W'(1) : tbc_pkg::DVS_W'(bpb_q);
    spc_val = (div_quot == '0) ? tbc_pkg::TPB_W'(1) : div_quot[tbc_pkg::TPB_W-1:0];
    sum = {1'b0, acc_q} + tbc_pkg::SUM_W'(carry_q);
  end

  // Divider operand selection: each operation has its own fixed width, so the
  // dividend is aligned by a constant shift.
  always_comb begin
    div_start = cmd_i.start;
    case (cmd_i.start_op)
      tbc_pkg::OP_DUR: begin
        div_dvd   = DUR_DVD;
        div_dvs   = tbc_pkg::DVS_W'(divr);
        div_iters = tbc_pkg::ITER_W'(tbc_pkg::US_W);
      end
      tbc_pkg::OP_REM: begin
        div_dvd   = sum;
        div_dvs   = tbc_pkg::DVS_W'(dur_q);
        div_iters = tbc_pkg::ITER_W'(tbc_pkg::DVD_W);
      end
      tbc_pkg::OP_SPC: begin
        div_dvd   = SPC_DVD;
        div_dvs   = bpb_c;
        div_iters = tbc_pkg::ITER_W'(tbc_pkg::TPB_W);
      end
      tbc_pkg::OP_BEAT: begin
        div_dvd   = tbc_pkg::DVD_W'(count_q[tbc_pkg::CNT_W-1:0])
                    << (tbc_pkg::DVD_W - tbc_pkg::CNT_W);
        div_dvs   = tbc_pkg::DVS_W'(spc_val);
        div_iters = tbc_pkg::ITER_W'(tbc_pkg::CNT_W);
      end
      default: begin
        div_dvd   = '0;
        div_dvs   = tbc_pkg::DVS_W'(1);
        div_iters = '0;
      end
    endcase
  end

  always_comb begin
    bpm_d     = bpm_q;
    bpb_d     = bpb_q;
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    dur_d     = dur_q;
    carry_n_d = carry_n_q;
    fire_d    = fire_q;
    beat_d    = beat_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        tbc_pkg::REG_TEMPO_BPM:     bpm_d = cfg_data_i[tbc_pkg::BPM_W-1:0];
        tbc_pkg::REG_BEATS_PER_BAR: bpb_d = cfg_data_i[tbc_pkg::BPB_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.cap) begin
      mode_d    = s_tuser_i;
      elapsed_d = s_tdata_i[tbc_pkg::ELAPSED_W-1:0];
      fire_d    = 1'b0;
      beat_d    = 1'b0;
    end

    if (cmd_i.chk) begin
      fire_d = sts_o.sum_ge;
    end

    if (cmd_i.take) begin
      case (cmd_i.take_op)
        tbc_pkg::OP_DUR: begin
          dur_d = (div_quot == '0) ? tbc_pkg::DUR_W'(1) : div_quot[tbc_pkg::DUR_W-1:0];
        end
        tbc_pkg::OP_REM:  carry_n_d = div_rem[tbc_pkg::DUR_W-1:0];
        tbc_pkg::OP_SPC:  beat_d = count_q[tbc_pkg::IDX_W-1] &&
                                   (spc_val == tbc_pkg::TPB_W'(1));
        tbc_pkg::OP_BEAT: beat_d = (div_rem == '0);
        default: ;
      endcase
    end
  end

  // Commit of the item's effect on the clock state, and the result word.
  always_comb begin
    playing_d = playing_q;
    carry_d   = carry_q;
    acc_d     = acc_q;
    count_d   = count_q;
    acc_base  = fire_q ? '0 : acc_q;
    acc_sum   = {1'b0, acc_base} + tbc_pkg::SUM_W'(elapsed_q);
    count_inc = (count_q == tbc_pkg::IDX_W'(tbc_pkg::TICKS_PER_BAR - 1)) ?
                '0 : count_q + tbc_pkg::IDX_W'(1);
    if (cmd_i.commit) begin
      case (mode_q)
        tbc_pkg::MODE_START: begin
          playing_d = 1'b1;
          carry_d   = '0;
          acc_d     = '0;
          count_d   = '1;
        end
        tbc_pkg::MODE_STOP: playing_d = 1'b0;
        tbc_pkg::MODE_ADVANCE: begin
          if (playing_q) begin
            if (fire_q) begin
              carry_d = carry_n_q;
              count_d = count_inc;
            end
            acc_d = acc_sum[tbc_pkg::ACC_W] ? '1 : acc_sum[tbc_pkg::ACC_W-1:0];
          end
        end
        default: ;
      endcase
    end

    out_free  = !m_valid_q || m_tready_i;
    m_valid_d = cmd_i.commit ? 1'b1 : (m_tready_i ? 1'b0 : m_valid_q);
    m_data_d  = m_data_q;
    if (cmd_i.commit) begin
      m_data_d = '0;
      m_data_d[0] = fire_q;
      m_data_d[1] = beat_q;
      m_data_d[tbc_pkg::IDX_W+1:2] = count_d;
      m_data_d[tbc_pkg::IDX_W+2] = playing_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpm_q     <= tbc_pkg::BPM_W'(120);
      bpb_q     <= tbc_pkg::BPB_W'(4);
      playing_q <= 1'b0;
      carry_q   <= '0;
      acc_q     <= '0;
      count_q   <= '1;
      fire_q    <= 1'b0;
      beat_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      bpm_q     <= bpm_d;
      bpb_q     <= bpb_d;
      playing_q <= playing_d;
      carry_q   <= carry_d;
      acc_q     <= acc_d;
      count_q   <= count_d;
      fire_q    <= fire_d;
      beat_q    <= beat_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    elapsed_q <= elapsed_d;
    dur_q     <= dur_d;
    carry_n_q <= carry_n_d;
    m_data_q  <= m_data_d;
  end

  always_comb begin
    sts_o.go_adv   = (s_tuser_i == tbc_pkg::MODE_ADVANCE) && playing_q;
    sts_o.div_busy = div_busy;
    sts_o.sum_ge   = (sum >= tbc_pkg::SUM_W'(dur_q));
    sts_o.cnt_neg  = count_q[tbc_pkg::IDX_W-1];
    sts_o.out_free = out_free;
  end

  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = m_valid_q;
  assign m_tdata_o   = m_data_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[tbc_pkg::IDX_W-1] && (&count_q)) ||
    (!count_q[tbc_pkg::IDX_W-1] && (count_q < tbc_pkg::IDX_W'(tbc_pkg::TICKS_PER_BAR))))
    else $error("tick counter out of range");

  a_rem_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && (cmd_i.take_op == tbc_pkg::OP_REM)) |-> fire_q)
    else $error("carry remainder taken without a tick");

endmodule

FILE: rtl/tbc_ctrl.sv
module tbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  tbc_pkg::tbc_sts_t  sts_i,
  output tbc_pkg::tbc_cmd_t  cmd_o
);

  tbc_pkg::tbc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      tbc_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.cap = 1'b1;
          if (sts_i.go_adv) begin
            cmd_o.start    = 1'b1;
            cmd_o.start_op = tbc_pkg::OP_DUR;
            state_d        = tbc_pkg::ST_DUR;
          end else begin
            state_d = tbc_pkg::ST_DONE;
          end
        end
      end
      tbc_pkg::ST_DUR: begin
        if (!sts_i.div_busy) begin
          cmd_o.take    = 1'b1;
          cmd_o.take_op = tbc_pkg::OP_DUR;
          state_d       = tbc_pkg::ST_CHK;
        end
      end
      tbc_pkg::ST_CHK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.sum_ge) begin
          cmd_o.start    = 1'b1;
          cmd_o.start_op = tbc_pkg::OP_REM;
          state_d        = tbc_pkg::ST_REM;
        end else begin
          state_d = tbc_pkg::ST_DONE;
        end
      end
      tbc_pkg::ST_REM: begin
        if (!sts_i.div_busy) begin
          cmd_o.take     = 1'b1;
          cmd_o.take_op  = tbc_pkg::OP_REM;
          cmd_o.start    = 1'b1;
          cmd_o.start_op = tbc_pkg::OP_SPC;
          state_d        = tbc_pkg::ST_SPC;
        end
      end
      tbc_pkg::ST_SPC: begin
        if (!sts_i.div_busy) begin
          cmd_o.take    = 1'b1;
          cmd_o.take_op = tbc_pkg::OP_SPC;
          // Before the first tick the beat follows from the spacing alone.
          if (sts_i.cnt_neg) begin
            state_d = tbc_pkg::ST_DONE;
          end else begin
            cmd_o.start    = 1'b1;
            cmd_o.start_op = tbc_pkg::OP_BEAT;
            state_d        = tbc_pkg::ST_BEAT;
          end
        end
      end
      tbc_pkg::ST_BEAT: begin
        if (!sts_i.div_busy) begin
          cmd_o.take    = 1'b1;
          cmd_o.take_op = tbc_pkg::OP_BEAT;
          state_d       = tbc_pkg::ST_DONE;
        end
      end
      tbc_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = tbc_pkg::ST_IDLE;
        end
      end
      default: state_d = tbc_pkg::ST_IDLE;
    endcase
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result committed into a full output register");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q != tbc_pkg::ST_IDLE))
    else $error("request accepted but controller stayed idle");

endmodule

FILE: tb/sv/tempo_tick_beat_clock_tb.sv
module tempo_tick_beat_clock_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_W'(3);

  typedef struct {
    logic             tick;
    logic             beat;
    logic [IDX_W-1:0] idx;
    logic             running;
  } tick_word_t;

  // Tracks the tempo clock's state and holds the result words still owed by the block.
  class tick_tracker;
    logic [BPM_W-1:0] bpm;
    logic [BPB_W-1:0] bpb;
    bit               playing;
    int unsigned      carry;
    int unsigned      acc;
    int               tick_count;
    tick_word_t       owed_words[$];
    int               errors;
    int               requests;
    int               ticks;
    int               beats;
    int               wraps;

    function new();
      bpm        = BPM_W'(120);
      bpb        = BPB_W'(4);
      playing    = 1'b0;
      carry      = 0;
      acc        = 0;
      tick_count = -1;
      errors     = 0;
      requests   = 0;
      ticks      = 0;
      beats      = 0;
      wraps      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_TEMPO_BPM) begin
        bpm = data[BPM_W-1:0];
      end else if (index == REG_BEATS_PER_BAR) begin
        bpb = data[BPB_W-1:0];
      end
    endfunction

    function int unsigned tick_len();
      int unsigned b;
      int unsigned d;
      b = bpm;
      if (b < BPM_MIN) begin
        b = BPM_MIN;
      end else if (b > BPM_MAX) begin
        b = BPM_MAX;
      end
      d = US_PER_MIN / (b * QUARTER_TICKS);
      return (d == 0) ? 1 : d;
    endfunction

    function int waiting();
      return owed_words.size();
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [ELAPSED_W-1:0] us);
      tick_word_t      w;
      int unsigned     dur;
      int unsigned     spacing;
      longint unsigned sum;
      w.tick = 1'b0;
      w.beat = 1'b0;
      requests++;
      if (mode == MODE_START) begin
        playing    = 1'b1;
        carry      = 0;
        acc        = 0;
        tick_count = -1;
      end else if (mode == MODE_STOP) begin
        playing = 1'b0;
      end else if (mode == MODE_ADVANCE && playing) begin
        dur = tick_len();
        sum = acc;
        sum += carry;
        // The tick test looks at the time gathered before this advance is added.
        if (sum >= dur) begin
          spacing = TICKS_PER_BAR / ((bpb == 0) ? 1 : bpb);
          if (spacing == 0) begin
            spacing = 1;
          end
          if (tick_count < 0) begin
            w.beat = (spacing == 1);
          end else begin
            w.beat = ((tick_count % spacing) == 0);
          end
          carry  = sum % dur;
          acc    = 0;
          w.tick = 1'b1;
          if (tick_count == TICKS_PER_BAR - 1) begin
            wraps++;
          end
          tick_count = (tick_count + 1) % TICKS_PER_BAR;
          ticks++;
          if (w.beat) begin
            beats++;
          end
        end
        sum = acc;
        sum += us;
        acc = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
      w.idx     = tick_count[IDX_W-1:0];
      w.running = playing;
      owed_words.push_back(w);
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] data);
      tick_word_t w;
      if (owed_words.size() == 0) begin
        errors++;
        $error("result word %h arrived with no request outstanding", data);
        return;
      end
      w = owed_words.pop_front();
      if (data[0] !== w.tick) begin
        errors++;
        $error("tick: expected %0b, got %0b", w.tick, data[0]);
      end
      if (data[1] !== w.beat) begin
        errors++;
        $error("beat: expected %0b, got %0b", w.beat, data[1]);
      end
      if (data[IDX_W+1:2] !== w.idx) begin
        errors++;
        $error("tick_index: expected %0d, got %0d", $signed(w.idx), $signed(data[IDX_W+1:2]));
      end
      if (data[IDX_W+2] !== w.running) begin
        errors++;
        $error("running: expected %0b, got %0b", w.running, data[IDX_W+2]);
      end
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   s_tvalid_i  = 1'b0;
  logic                   s_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata_i   = '0;
  logic [MODE_W-1:0]      s_tuser_i   = MODE_ADVANCE;
  logic                   m_tvalid_o;
  logic                   m_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_TEMPO_BPM;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  tick_tracker board;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycles        = 0;

  tempo_tick_beat_clock dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      if (rst_ni && m_tvalid_o && m_tready_i) begin
        board.check_word(m_tdata_o);
      end
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Valid stays high into the next request unless a gap is drawn, so it is
  // never lowered and raised within one time step.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ELAPSED_W-1:0] us);
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= mode;
    s_tdata_i  <= IN_TDATA_W'(us);
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    board.note_request(mode, us);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
  endtask

  task automatic pause_sender();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.waiting() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(index, CFG_DATA_W'(value));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A steady phase keeps every advance at or above one tick length where that
  // fits in 16 bits, so a long one runs the counter through a whole bar and wraps it.
  task automatic run_phase(input int unsigned bpm, input int unsigned bpb, input int n,
                           input bit steady, input int s_pct, input int r_pct);
    int unsigned       dur;
    int unsigned       hi;
    int unsigned       lo;
    int unsigned       pick;
    logic [MODE_W-1:0] mode;
    logic [ELAPSED_W-1:0] us;
    pause_sender();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_reg(REG_TEMPO_BPM, bpm);
    write_reg(REG_BEATS_PER_BAR, bpb);
    dur = board.tick_len();
    hi  = (2 * dur > 65535) ? 65535 : 2 * dur;
    lo  = (dur > hi) ? hi : dur;
    send_request(MODE_START, ELAPSED_W'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        pause_sender();
      end
      pick = $urandom_range(99);
      mode = MODE_ADVANCE;
      us   = ELAPSED_W'($urandom_range(hi, 0));
      if (steady) begin
        us = ELAPSED_W'($urandom_range(hi, lo));
      end else if (!board.playing && pick < 50) begin
        mode = MODE_START;
      end else if (pick < 4) begin
        mode = MODE_START;
      end else if (pick < 7) begin
        mode = MODE_STOP;
      end else if (pick < 9) begin
        mode = MODE_UNUSED;
      end else if (pick < 19) begin
        us = $urandom_range(1) ? '1 : '0;
      end else if (pick < 39) begin
        us = ELAPSED_W'($urandom);
      end
      send_request(mode, us);
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 21;
    recv_idle_pct = 55;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset tempo of 120 bpm gives a tick of 2083 us.
    send_request(MODE_UNUSED, '1);
    send_request(MODE_ADVANCE, ELAPSED_W'(1000));
    send_request(MODE_STOP, '0);
    send_request(MODE_START, '0);
    send_request(MODE_ADVANCE, '0);
    send_request(MODE_ADVANCE, ELAPSED_W'(2083));
    send_request(MODE_ADVANCE, ELAPSED_W'(5));
    send_request(MODE_ADVANCE, '1);
    send_request(MODE_ADVANCE, '0);
    send_request(MODE_STOP, '1);
    send_request(MODE_ADVANCE, ELAPSED_W'(100));
    send_request(MODE_UNUSED, '0);
    send_request(MODE_ADVANCE, '1);
    send_request(MODE_START, ELAPSED_W'(12345));
    send_request(MODE_ADVANCE, ELAPSED_W'(2082));
    send_request(MODE_ADVANCE, ELAPSED_W'(1));
    send_request(MODE_ADVANCE, '0);
    send_request(MODE_ADVANCE, '0);

    run_phase(120, 4, 220, 1'b0, 21, 55);
    run_phase(0, 0, 180, 1'b0, 21, 55);
    run_phase(1023, 31, 220, 1'b0, 55, 21);
    run_phase(300, 16, 971, 1'b1, 55, 21);
    run_phase(1, 1, 150, 1'b0, 0, 0);
    run_phase($urandom_range(1023, 0), $urandom_range(31, 0), 150, 1'b0, 0, 0);

    pause_sender();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests over seven tempo and metre settings, clamped tempos, stops and unused modes included.",
             board.requests);
    $display("The clock fired %0d ticks, flagged %0d beats and wrapped the bar %0d times.",
             board.ticks, board.beats, board.wraps);
    if (board.errors == 0 && board.waiting() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tbc_pkg.sv
rtl/tbc_div.sv
rtl/tbc_dp.sv
rtl/tbc_ctrl.sv
rtl/tempo_tick_beat_clock.sv
tb/sv/tempo_tick_beat_clock_tb.sv
